// ===== rtl/core/tbe_pkg.sv =====
// Shared types and constants for the timing budget encoder.
package tbe_pkg;

	localparam int IN_W  = 48;
	localparam int OUT_W = 80;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_SMALL = 2'd1;
	localparam logic [1:0] ST_HIGH  = 2'd2;
	localparam logic [1:0] ST_ZERO  = 2'd3;

	localparam logic [2:0] DS_PLL = 3'd0;
	localparam logic [2:0] DS_PC  = 3'd1;
	localparam logic [2:0] DS_MMA = 3'd2;
	localparam logic [2:0] DS_RGA = 3'd3;
	localparam logic [2:0] DS_MMB = 3'd4;
	localparam logic [2:0] DS_RGB = 3'd5;

	localparam logic [31:0] PLL_NUM     = 32'h4000_0000;
	localparam logic [31:0] BUDGET_MIN  = 32'd4528;
	localparam logic [31:0] EXCESS_MAX  = 32'd1100000;
	localparam logic [11:0] PLL_SCALE   = 12'd2304;
	localparam logic [31:0] PC_NUM      = 32'd1000 << 12;
	localparam logic [31:0] MM_NUM      = 32'd1 << 12;
	localparam logic [15:0] FOSC_RESET  = 16'd1;

	typedef struct packed {
		logic       load;
		logic       div_start;
		logic       div_store;
		logic [2:0] div_sel;
		logic       mul0;
		logic       mula;
		logic       mulb;
		logic       set_zero;
		logic       emit;
	} tbe_cmd_t;

	typedef struct packed {
		logic budget_err;
		logic div_done;
		logic macro_zero;
		logic out_free;
	} tbe_stat_t;

endpackage

// ===== rtl/core/tof_timing_budget_encoder.sv =====
// Top level of the time-of-flight timing budget encoder.
// A valid budget takes six runs of the shared divider plus sequencing; a budget error
// goes straight to the result, and a zero macro period ends after the first division.
// A new request is taken only once the previous one has been placed in the output register.
// A finished result waits in the output register while the next request is taken.
// Reset arst_n is asynchronous, active low: clears control and sets fast_osc_freq to 1.
module tof_timing_budget_encoder (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_wr_en,
	input  logic [15:0]               cfg_wr_data,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  logic [tbe_pkg::IN_W-1:0]  s_tdata,  // budget, vcsel_period_a, vcsel_period_b
	output logic                      m_tvalid,
	input  logic                      m_tready,
	output logic [tbe_pkg::OUT_W-1:0] m_tdata   // status, phasecal_timeout, mm_timeout_a,
	                                            // range_timeout_a, mm_timeout_b,
	                                            // range_timeout_b, zero pad
);
	import tbe_pkg::*;

	tbe_cmd_t  cmd;
	tbe_stat_t stat;

	tbe_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	tbe_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_data     (s_tdata),
		.cmd         (cmd),
		.stat        (stat),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.out_data    (m_tdata)
	);

endmodule

// ===== rtl/core/tbe_div.sv =====
// Shared iterative 32-bit unsigned divider, one quotient bit per cycle.
module tbe_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] num,
	input  logic [31:0] den,
	output logic        done,
	output logic [31:0] quo
);
	logic [31:0] rem_q;
	logic [31:0] quo_q;
	logic [31:0] den_q;
	logic [4:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [32:0] trial;
	logic        fits;

	assign trial = {rem_q, quo_q[31]};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= 5'd0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 5'd0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= 32'd0;
			quo_q <= num;
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= fits ? 32'(trial - {1'b0, den_q}) : trial[31:0];
			quo_q <= {quo_q[30:0], fits};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy_q))
		else $error("divider done without a run");
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> busy_q)
		else $error("divider did not start");

endmodule

// ===== rtl/core/tbe_datapath.sv =====
// Datapath: input capture, macro period, shared divider, word encoding, output register.
module tbe_datapath (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wr_en,
	input  logic [15:0]                    cfg_wr_data,
	input  logic [tbe_pkg::IN_W-1:0]       in_data,
	input  tbe_pkg::tbe_cmd_t              cmd,
	output tbe_pkg::tbe_stat_t             stat,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [tbe_pkg::OUT_W-1:0]      out_data
);
	import tbe_pkg::*;

	function automatic logic [15:0] enc_word(input logic [15:0] c);
		logic [15:0] v;
		logic [3:0]  e;
		logic [15:0] sh;
		v = c - 16'd1;
		e = 4'd0;
		for (int i = 8; i < 16; i++) begin
			if (v[i]) e = 4'(i - 7);
		end
		sh = v >> e;
		return (c == 16'd0) ? 16'd0 : {4'd0, e, sh[7:0]};
	endfunction

	logic [15:0] fosc_q;
	logic [1:0]  status_q;
	logic [19:0] r_q;
	logic [7:0]  va_q;
	logic [7:0]  vb_q;
	logic [30:0] pll_q;
	logic [25:0] m0_q;
	logic [25:0] macro_a_q;
	logic [25:0] macro_b_q;
	logic [7:0]  pc_q;
	logic [15:0] mm_a_q;
	logic [15:0] rg_a_q;
	logic [15:0] mm_b_q;
	logic [15:0] rg_b_q;
	logic        out_valid_q;
	logic [OUT_W-1:0] out_data_q;

	logic [31:0] budget;
	logic [31:0] excess;
	logic [1:0]  bud_status;
	logic [7:0]  pclk_a;
	logic [7:0]  pclk_b;
	logic [42:0] m0_prod;
	logic [33:0] ma_prod;
	logic [33:0] mb_prod;
	logic [25:0] macro_sel;
	logic [31:0] t_shift;
	logic [31:0] div_num;
	logic [31:0] div_den;
	logic        div_done;
	logic [31:0] div_quo;

	assign budget = in_data[31:0];
	assign excess = budget - BUDGET_MIN;

	always_comb begin
		if (budget <= BUDGET_MIN) begin
			bud_status = ST_SMALL;
		end else if (excess > EXCESS_MAX) begin
			bud_status = ST_HIGH;
		end else begin
			bud_status = ST_OK;
		end
	end

	assign pclk_a  = 8'((va_q + 8'd1) << 1);
	assign pclk_b  = 8'((vb_q + 8'd1) << 1);
	assign m0_prod = 43'(pll_q) * 43'(PLL_SCALE);
	assign ma_prod = 34'(m0_q) * 34'(pclk_a);
	assign mb_prod = 34'(m0_q) * 34'(pclk_b);

	always_comb begin
		macro_sel = macro_a_q;
		t_shift   = MM_NUM;
		div_num   = PLL_NUM;
		div_den   = {16'd0, fosc_q};
		case (cmd.div_sel)
			DS_PLL: begin
				macro_sel = macro_a_q;
				t_shift   = MM_NUM;
			end
			DS_PC: begin
				macro_sel = macro_a_q;
				t_shift   = PC_NUM;
			end
			DS_MMA: begin
				macro_sel = macro_a_q;
				t_shift   = MM_NUM;
			end
			DS_RGA: begin
				macro_sel = macro_a_q;
				t_shift   = {r_q, 12'd0};
			end
			DS_MMB: begin
				macro_sel = macro_b_q;
				t_shift   = MM_NUM;
			end
			DS_RGB: begin
				macro_sel = macro_b_q;
				t_shift   = {r_q, 12'd0};
			end
			default: begin
				macro_sel = macro_a_q;
				t_shift   = MM_NUM;
			end
		endcase
		if (cmd.div_sel != DS_PLL) begin
			div_num = t_shift + {7'd0, macro_sel[25:1]};
			div_den = {6'd0, macro_sel};
		end
	end

	tbe_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quo    (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fosc_q      <= FOSC_RESET;
			status_q    <= ST_OK;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) fosc_q <= cfg_wr_data;
			if (cmd.load) begin
				status_q <= bud_status;
			end else if (cmd.set_zero) begin
				status_q <= ST_ZERO;
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			r_q  <= excess[20:1];
			va_q <= in_data[39:32];
			vb_q <= in_data[47:40];
		end
		if (cmd.mul0) m0_q <= m0_prod[31:6];
		if (cmd.mula) macro_a_q <= ma_prod[31:6];
		if (cmd.mulb) macro_b_q <= mb_prod[31:6];
		if (cmd.div_store) begin
			case (cmd.div_sel)
				DS_PLL:  pll_q  <= (fosc_q == 16'd0) ? 31'd0 : div_quo[30:0];
				DS_PC:   pc_q   <= (|div_quo[31:8]) ? 8'hFF : div_quo[7:0];
				DS_MMA:  mm_a_q <= enc_word(div_quo[15:0]);
				DS_RGA:  rg_a_q <= enc_word(div_quo[15:0]);
				DS_MMB:  mm_b_q <= enc_word(div_quo[15:0]);
				DS_RGB:  rg_b_q <= enc_word(div_quo[15:0]);
				default: pc_q   <= pc_q;
			endcase
		end
		if (cmd.emit) begin
			if (status_q != ST_OK) begin
				out_data_q <= {6'd0, 72'd0, status_q};
			end else begin
				out_data_q <= {6'd0, rg_b_q, mm_b_q, rg_a_q, mm_a_q, pc_q, status_q};
			end
		end
	end

	assign stat.budget_err = status_q != ST_OK;
	assign stat.div_done   = div_done;
	assign stat.macro_zero = (macro_a_q == 26'd0) || (macro_b_q == 26'd0);
	assign stat.out_free   = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	a_err_words_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_data_q[1:0] != ST_OK) |-> out_data_q[OUT_W-1:2] == '0)
		else $error("error result carries nonzero words");
	a_emit_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (!out_valid_q || out_ready))
		else $error("result overwritten before it was taken");

endmodule

// ===== rtl/core/tbe_ctrl.sv =====
// Controller: sequences budget check, macro period, divisions and result hand-off.
module tbe_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  tbe_pkg::tbe_stat_t stat,
	output tbe_pkg::tbe_cmd_t  cmd
);
	import tbe_pkg::*;

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_CHK   = 4'd1;
	localparam logic [3:0] S_START = 4'd2;
	localparam logic [3:0] S_WAIT  = 4'd3;
	localparam logic [3:0] S_MUL0  = 4'd4;
	localparam logic [3:0] S_MULA  = 4'd5;
	localparam logic [3:0] S_MULB  = 4'd6;
	localparam logic [3:0] S_ZCHK  = 4'd7;
	localparam logic [3:0] S_FIN   = 4'd8;

	logic [3:0] state_q;
	logic [3:0] state_d;
	logic [2:0] sel_q;
	logic [2:0] sel_d;

	always_comb begin
		state_d       = state_q;
		sel_d         = sel_q;
		cmd           = '0;
		cmd.div_sel   = sel_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_CHK;
				end
			end
			S_CHK: begin
				if (stat.budget_err) begin
					state_d = S_FIN;
				end else begin
					sel_d   = DS_PLL;
					state_d = S_START;
				end
			end
			S_START: begin
				cmd.div_start = 1'b1;
				state_d       = S_WAIT;
			end
			S_WAIT: begin
				if (stat.div_done) begin
					cmd.div_store = 1'b1;
					if (sel_q == DS_PLL) begin
						state_d = S_MUL0;
					end else if (sel_q == DS_RGB) begin
						state_d = S_FIN;
					end else begin
						sel_d   = sel_q + 3'd1;
						state_d = S_START;
					end
				end
			end
			S_MUL0: begin
				cmd.mul0 = 1'b1;
				state_d  = S_MULA;
			end
			S_MULA: begin
				cmd.mula = 1'b1;
				state_d  = S_MULB;
			end
			S_MULB: begin
				cmd.mulb = 1'b1;
				state_d  = S_ZCHK;
			end
			S_ZCHK: begin
				if (stat.macro_zero) begin
					cmd.set_zero = 1'b1;
					state_d      = S_FIN;
				end else begin
					sel_d   = DS_PC;
					state_d = S_START;
				end
			end
			S_FIN: begin
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			sel_q   <= DS_PLL;
		end else begin
			state_q <= state_d;
			sel_q   <= sel_d;
		end
	end

	assign in_ready = state_q == S_IDLE;

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("new request taken while one is in flight");
	a_store_on_done: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_store |-> (stat.div_done && state_q == S_WAIT))
		else $error("quotient stored without a finished division");

endmodule
